// ----- rtl/rdc_pkg.sv -----
// shared codes and field widths for the bitfield read cache
`default_nettype none
package rdc_pkg;
    // input modes (tuser on the slave side)
    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_FILL = 2'd1;
    localparam logic [1:0] MODE_DROP = 2'd2;

    // result kinds (tuser on the master side)
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_FILLREQ = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 112;
    localparam int BYTE_W     = 45;
    localparam int LNUM_OUT_W = 39;
endpackage
`default_nettype wire

// ----- rtl/rdc_ram.sv -----
// single write port, single registered read port memory
`default_nettype none
module rdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/direct_mapped_read_cache_bitfield_top.sv -----
// top level of the direct-mapped bitfield read cache with its sequencer
`default_nettype none
// Direct-mapped read cache with tags and line data in synchronous RAMs.
// CACHE_ENTRIES and LINE_BYTES must be powers of two. A read that hits one
// line takes one tag lookup (S_TAG0) and two data word reads (S_WORD0,
// S_WORD1) before its result goes to the output register. A read that spans
// two lines needs a second lookup (S_TAG1) on the same RAM port. A read that
// misses emits one or two fill requests once its lookups are done. Fill
// words are taken one a cycle. The word that finishes the last missing line
// is followed by a state (S_RD) that lets it settle in the data RAM and then
// the same two data word reads. A drop walks the whole tag RAM, one entry a
// cycle, and gives its result after the last entry. An error result comes in
// the cycle after its transfer. One item is worked on at a time: input waits
// while a result is held in the output register, and the next transfer can
// be accepted in the cycle after the last result of an item is taken.
module direct_mapped_read_cache_bitfield_top #(
    parameter int CACHE_ENTRIES = 64,
    parameter int LINE_BYTES    = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // bit_offset, bit_count, fill_word, drop_start, drop_length, zero pad
    input  wire logic [rdc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  wire logic [1:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // read_value, line_number, first_hit, second_hit, zero pad
    output logic      [rdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic      [1:0]                     m_axis_tuser,
    output logic                                m_axis_tlast
);
    import rdc_pkg::*;

    localparam int LINE_WORDS = LINE_BYTES / 8;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int WORD_W = $clog2(LINE_WORDS);
    localparam int PG_W   = (WORD_W > 0) ? WORD_W : 1;
    localparam int WA_W   = IDX_W + WORD_W;
    localparam int LN_W   = BYTE_W + 1 - OFF_W;
    localparam int TAG_W  = LN_W - IDX_W;
    localparam int DEPTH_W = CACHE_ENTRIES * LINE_WORDS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAG0  = 3'd1;
    localparam logic [2:0] S_TAG1  = 3'd2;
    localparam logic [2:0] S_WORD0 = 3'd3;
    localparam logic [2:0] S_WORD1 = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_DROP  = 3'd6;
    localparam logic [2:0] S_RD    = 3'd7;

    // input fields
    logic [1:0]  mode_in;
    logic [47:0] bit_offset;
    logic [6:0]  bit_count;
    logic [63:0] fill_word;
    logic [44:0] drop_start;
    logic [44:0] drop_length;

    assign mode_in     = s_axis_tuser;
    assign bit_offset  = s_axis_tdata[47:0];
    assign bit_count   = s_axis_tdata[54:48];
    assign fill_word   = s_axis_tdata[118:55];
    assign drop_start  = s_axis_tdata[163:119];
    assign drop_length = s_axis_tdata[208:164];

    logic [2:0]            state_reg, state_next;
    logic [BYTE_W-1:0]     boff_reg, boff_next;
    logic [6:0]            cnt_reg, cnt_next;
    logic [LN_W-1:0]       l0_reg, l0_next, l1_reg, l1_next;
    logic                  hit0_reg, hit0_next, hit1_reg, hit1_next;
    logic                  pend_reg, pend_next;
    logic                  need0_reg, need0_next, need1_reg, need1_next;
    logic [PG_W-1:0]       prog_reg, prog_next;
    logic                  second_reg, second_next;
    logic [IDX_W-1:0]      dr_idx_reg, dr_idx_next;
    logic [LN_W-1:0]       dr_first_reg, dr_first_next;
    logic [LN_W:0]         dr_last_reg, dr_last_next;
    logic [63:0]           w0_reg, w0_next;
    logic                  ov_reg, ov_next;
    logic [1:0]            okind_reg, okind_next;
    logic [63:0]           oval_reg, oval_next;
    logic [LNUM_OUT_W-1:0] oline_reg, oline_next;
    logic                  oh0_reg, oh0_next, oh1_reg, oh1_next, olast_reg, olast_next;
    logic [63:0]           hitc_reg, hitc_next, missc_reg, missc_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;

    // memory ports
    logic              tag_we;
    logic [IDX_W-1:0]  tag_waddr, tag_raddr;
    logic [TAG_W-1:0]  tag_wdata, tag_rdata;
    logic              dat_we;
    logic [WA_W-1:0]   dat_waddr, dat_raddr;
    logic [63:0]       dat_rdata;

    rdc_ram #(.WIDTH(TAG_W), .DEPTH(CACHE_ENTRIES)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    rdc_ram #(.WIDTH(64), .DEPTH(DEPTH_W)) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (fill_word),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    logic              s_fire, m_fire;
    logic [BYTE_W-1:0] byte_in;
    logic [3:0]        nbytes;
    logic [BYTE_W:0]   end_byte;
    logic [LN_W-1:0]   l0_in, l1_in;
    logic              rd_err;
    logic [BYTE_W+1:0] drop_end;
    logic [LN_W-1:0]   cmp_line, fill_line, walk_line;
    logic              tag_hit, two, h0, h1, decide, fill_done;
    logic [127:0]      pair;
    logic [63:0]       field, mask;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;

    // line span of an incoming read
    assign byte_in  = bit_offset[47:3];
    assign nbytes   = 4'((bit_count + 7'd7) >> 3);
    assign end_byte = {1'b0, byte_in} + (BYTE_W+1)'(nbytes) - (BYTE_W+1)'(1);
    assign l0_in    = LN_W'(byte_in >> OFF_W);
    assign l1_in    = LN_W'(end_byte >> OFF_W);
    assign rd_err   = (bit_offset[2:0] != 3'd0) || (bit_count == 7'd0)
                    || (bit_count > 7'd64) || pend_reg;
    assign drop_end = {2'b0, drop_start} + {2'b0, drop_length}
                    + (BYTE_W+2)'(LINE_BYTES - 1);

    // tag lookup compare
    assign cmp_line = (state_reg == S_TAG0) ? l0_reg : l1_reg;
    assign tag_hit  = valid_reg[cmp_line[IDX_W-1:0]] && (tag_rdata == cmp_line[LN_W-1:IDX_W]);
    assign two      = (l0_reg != l1_reg);
    assign h0       = (state_reg == S_TAG0) ? tag_hit : hit0_reg;
    assign h1       = (state_reg == S_TAG1) ? tag_hit : 1'b1;
    assign decide   = ((state_reg == S_TAG0) && !two) || (state_reg == S_TAG1);

    assign fill_line = need0_reg ? l0_reg : l1_reg;
    assign fill_done = (prog_reg == PG_W'(LINE_WORDS - 1));
    assign walk_line = {tag_rdata, dr_idx_reg};

    // field assembly from two adjacent words
    assign pair  = {dat_rdata, w0_reg} >> {boff_reg[2:0], 3'b000};
    assign mask  = (cnt_reg >= 7'd64) ? ~64'd0 : ((64'd1 << cnt_reg[5:0]) - 64'd1);
    assign field = pair[63:0] & mask;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        boff_next    = boff_reg;
        cnt_next     = cnt_reg;
        l0_next      = l0_reg;
        l1_next      = l1_reg;
        hit0_next    = hit0_reg;
        hit1_next    = hit1_reg;
        pend_next    = pend_reg;
        need0_next   = need0_reg;
        need1_next   = need1_reg;
        prog_next    = prog_reg;
        second_next  = second_reg;
        dr_idx_next  = dr_idx_reg;
        dr_first_next = dr_first_reg;
        dr_last_next = dr_last_reg;
        w0_next      = w0_reg;
        ov_next      = ov_reg;
        okind_next   = okind_reg;
        oval_next    = oval_reg;
        oline_next   = oline_reg;
        oh0_next     = oh0_reg;
        oh1_next     = oh1_reg;
        olast_next   = olast_reg;
        hitc_next    = hitc_reg;
        missc_next   = missc_reg;
        valid_next   = valid_reg;
        tag_we       = 1'b0;
        tag_waddr    = fill_line[IDX_W-1:0];
        tag_wdata    = fill_line[LN_W-1:IDX_W];
        tag_raddr    = l0_in[IDX_W-1:0];
        dat_we       = 1'b0;
        dat_waddr    = (WA_W'(fill_line[IDX_W-1:0]) << WORD_W) | WA_W'(prog_reg);
        dat_raddr    = boff_reg[WA_W+2:3];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    // error result unless a path below takes over
                    okind_next = KIND_ERROR;
                    oval_next  = '0;
                    oline_next = '0;
                    oh0_next   = 1'b0;
                    oh1_next   = 1'b0;
                    olast_next = 1'b1;
                    priority case (mode_in)
                        MODE_READ:
                        begin
                            if (rd_err)
                            begin
                                ov_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                boff_next  = byte_in;
                                cnt_next   = bit_count;
                                l0_next    = l0_in;
                                l1_next    = l1_in;
                                state_next = S_TAG0;
                            end
                        end
                        MODE_FILL:
                        begin
                            if (!pend_reg)
                            begin
                                ov_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                dat_we    = 1'b1;
                                prog_next = prog_reg + PG_W'(1);
                                if (fill_done)
                                begin
                                    prog_next = '0;
                                    tag_we    = 1'b1;
                                    valid_next[fill_line[IDX_W-1:0]] = 1'b1;
                                    if (need0_reg)
                                    begin
                                        need0_next = 1'b0;
                                    end
                                    else
                                    begin
                                        need1_next = 1'b0;
                                    end
                                    if (!(need0_reg && need1_reg))
                                    begin
                                        pend_next  = 1'b0;
                                        state_next = S_RD;
                                    end
                                end
                            end
                        end
                        MODE_DROP:
                        begin
                            dr_first_next = LN_W'(drop_start >> OFF_W);
                            dr_last_next  = (LN_W+1)'(drop_end >> OFF_W);
                            dr_idx_next   = '0;
                            tag_raddr     = '0;
                            state_next    = S_DROP;
                        end
                        default:
                        begin
                            ov_next = 1'b1;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // last fill word is now in the RAM, read the first word
                state_next = S_WORD0;
            end
            S_TAG0, S_TAG1:
            begin
                tag_raddr = l1_reg[IDX_W-1:0];
                if (tag_hit)
                begin
                    hitc_next = hitc_reg + 64'd1;
                end
                else
                begin
                    missc_next = missc_reg + 64'd1;
                end
                if (state_reg == S_TAG0)
                begin
                    hit0_next = tag_hit;
                end
                hit1_next = h1;
                if (!decide)
                begin
                    state_next = S_TAG1;
                end
                else if (h0 && h1)
                begin
                    state_next = S_WORD0;
                end
                else
                begin
                    // start a fill sequence
                    pend_next   = 1'b1;
                    need0_next  = !h0;
                    need1_next  = !h1;
                    prog_next   = '0;
                    ov_next     = 1'b1;
                    okind_next  = KIND_FILLREQ;
                    oval_next   = '0;
                    oh0_next    = h0;
                    oh1_next    = h1;
                    oline_next  = LNUM_OUT_W'(h0 ? l1_reg : l0_reg);
                    olast_next  = h0 || h1;
                    second_next = !h0 && !h1;
                    state_next  = S_OUT;
                end
            end
            S_WORD0:
            begin
                dat_raddr  = boff_reg[WA_W+2:3] + WA_W'(1);
                w0_next    = dat_rdata;
                state_next = S_WORD1;
            end
            S_WORD1:
            begin
                ov_next    = 1'b1;
                okind_next = KIND_DATA;
                oval_next  = field;
                oline_next = '0;
                oh0_next   = hit0_reg;
                oh1_next   = hit1_reg;
                olast_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_fire)
                begin
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        oline_next  = LNUM_OUT_W'(l1_reg);
                        olast_next  = 1'b1;
                    end
                    else
                    begin
                        ov_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DROP:
            begin
                // compare the entry read last cycle, fetch the next one
                tag_raddr = dr_idx_reg + IDX_W'(1);
                if (valid_reg[dr_idx_reg] && (walk_line >= dr_first_reg)
                    && ({1'b0, walk_line} <= dr_last_reg))
                begin
                    valid_next[dr_idx_reg] = 1'b0;
                end
                dr_idx_next = dr_idx_reg + IDX_W'(1);
                if (dr_idx_reg == IDX_W'(CACHE_ENTRIES - 1))
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_DROP;
                    oval_next  = '0;
                    oline_next = '0;
                    oh0_next   = 1'b0;
                    oh1_next   = 1'b0;
                    olast_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            need0_reg  <= 1'b0;
            need1_reg  <= 1'b0;
            prog_reg   <= '0;
            second_reg <= 1'b0;
            ov_reg     <= 1'b0;
            hitc_reg   <= '0;
            missc_reg  <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            need0_reg  <= need0_next;
            need1_reg  <= need1_next;
            prog_reg   <= prog_next;
            second_reg <= second_next;
            ov_reg     <= ov_next;
            hitc_reg   <= hitc_next;
            missc_reg  <= missc_next;
            valid_reg  <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        boff_reg     <= boff_next;
        cnt_reg      <= cnt_next;
        l0_reg       <= l0_next;
        l1_reg       <= l1_next;
        hit0_reg     <= hit0_next;
        hit1_reg     <= hit1_next;
        dr_idx_reg   <= dr_idx_next;
        dr_first_reg <= dr_first_next;
        dr_last_reg  <= dr_last_next;
        w0_reg       <= w0_next;
        okind_reg    <= okind_next;
        oval_reg     <= oval_next;
        oline_reg    <= oline_next;
        oh0_reg      <= oh0_next;
        oh1_reg      <= oh1_next;
        olast_reg    <= olast_next;
    end

    // output channel
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {7'd0, oh1_reg, oh0_reg, oline_reg, oval_reg};
endmodule
`default_nettype wire
